// ----- hdl/sclk_pkg.sv -----
// Shared codes, constants and digit-split functions for the settable clock.
package sclk_pkg;

  // Event codes carried in the func field
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_MODE = 2'd1;
  localparam logic [1:0] FUNC_UP   = 2'd2;
  localparam logic [1:0] FUNC_DOWN = 2'd3;

  // Set modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SEC    = 2'd1;
  localparam logic [1:0] MODE_MIN    = 2'd2;
  localparam logic [1:0] MODE_HOUR   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_TPS     = 2'd0;
  localparam logic [1:0] REG_BLANK   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [3:0] TPS_RESET     = 4'd10;
  localparam logic [3:0] BLANK_RESET   = 4'd5;
  localparam logic [4:0] TIMEOUT_RESET = 5'd20;

  // Field limits
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [4:0] IDLE_MAX  = 5'd31;

  // Tens digit of a value below 60, by comparison
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if      (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Units digit: value minus ten times the tens digit
  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] r;
    t = tens_of(v);
    r = v - {t, 3'b000} - {2'b00, t, 1'b0};
    return r[3:0];
  endfunction

endpackage

// ----- hdl/sclk_in_if.sv -----
// Event channel: one key or tick word per handshake.
interface sclk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       keys_idle;

  modport source (output valid, output func, output keys_idle, input ready);
  modport sink   (input valid, input func, input keys_idle, output ready);
endinterface

// ----- hdl/sclk_out_if.sv -----
// Display channel: time digits, set mode and blank flag per word.
interface sclk_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] sec_ones;
  logic [2:0] sec_tens;
  logic [3:0] min_ones;
  logic [2:0] min_tens;
  logic [3:0] hour_ones;
  logic [1:0] hour_tens;
  logic [1:0] set_mode;
  logic       blank_selected;

  modport source (output valid, output sec_ones, output sec_tens, output min_ones,
                  output min_tens, output hour_ones, output hour_tens,
                  output set_mode, output blank_selected, input ready);
  modport sink   (input valid, input sec_ones, input sec_tens, input min_ones,
                  input min_tens, input hour_ones, input hour_tens,
                  input set_mode, input blank_selected, output ready);
endinterface

// ----- hdl/sclk_cfg_if.sv -----
// Configuration write channel: register index and data per word.
interface sclk_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/settable_clock_with_timeout.sv -----
// Top level: 24-hour key-settable clock with set-mode timeout.
//
//  channel  | dir | contents
//  ---------+-----+----------------------------------------------------
//  events   | in  | func, keys_idle
//  display  | out | six BCD digits, set_mode, blank_selected
//  cfg      | in  | index (0 ticks/s, 1 blank ticks, 2 timeout), data
//
//  For each event word, the state updates and the display word is
//  registered at the accepting edge, one word per clock while display.ready holds.
//  The display register is the only stage; events.ready is low only while
//  a display word waits and display.ready is low.
//  Reset (rst, synchronous) clears the time, mode, counters and registers
//  to their defaults; cfg is always ready.
module settable_clock_with_timeout (
  input  logic       clk,
  input  logic       rst,
  sclk_in_if.sink    events,
  sclk_out_if.source display,
  sclk_cfg_if.sink   cfg
);

  // Configuration registers
  logic [3:0] tps;
  logic [3:0] blank_ticks;
  logic [4:0] timeout;

  // Clock state
  logic [3:0] tick_count, tick_count_next;
  logic [5:0] seconds, seconds_next;
  logic [5:0] minutes, minutes_next;
  logic [4:0] hours, hours_next;
  logic [1:0] mode, mode_next;
  logic [4:0] idle_seconds, idle_seconds_next;

  logic [3:0] tick_inc;
  logic       sec_done;
  logic       blank_next;
  logic       in_fire;

  assign in_fire      = events.valid && events.ready;
  assign events.ready = !display.valid || display.ready;
  assign cfg.ready    = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tps         <= sclk_pkg::TPS_RESET;
      blank_ticks <= sclk_pkg::BLANK_RESET;
      timeout     <= sclk_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        sclk_pkg::REG_TPS:     tps         <= cfg.data[3:0];
        sclk_pkg::REG_BLANK:   blank_ticks <= cfg.data[3:0];
        sclk_pkg::REG_TIMEOUT: timeout     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Next state for one event word
  always_comb begin
    tick_count_next   = tick_count;
    seconds_next      = seconds;
    minutes_next      = minutes;
    hours_next        = hours;
    mode_next         = mode;
    idle_seconds_next = idle_seconds;
    tick_inc          = tick_count + 4'd1;
    sec_done          = 1'b0;

    case (events.func)
      sclk_pkg::FUNC_TICK: begin
        // a zero tps behaves as one; wrap of the 4-bit count also ends a second
        if (tick_inc >= tps || tick_inc == 4'd0) begin
          tick_count_next = 4'd0;
          sec_done        = 1'b1;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      sclk_pkg::FUNC_MODE: begin
        mode_next         = mode + 2'd1;
        idle_seconds_next = 5'd0;
      end
      sclk_pkg::FUNC_UP: begin
        case (mode)
          sclk_pkg::MODE_SEC:
            seconds_next = (seconds >= sclk_pkg::SEC_MAX) ? 6'd0 : seconds + 6'd1;
          sclk_pkg::MODE_MIN:
            minutes_next = (minutes >= sclk_pkg::MIN_MAX) ? 6'd0 : minutes + 6'd1;
          sclk_pkg::MODE_HOUR:
            hours_next = (hours >= sclk_pkg::HOUR_MAX) ? 5'd0 : hours + 5'd1;
          default: ;
        endcase
      end
      default: begin
        case (mode)
          sclk_pkg::MODE_SEC:
            seconds_next = (seconds == 6'd0) ? sclk_pkg::SEC_MAX : seconds - 6'd1;
          sclk_pkg::MODE_MIN:
            minutes_next = (minutes == 6'd0) ? sclk_pkg::MIN_MAX : minutes - 6'd1;
          sclk_pkg::MODE_HOUR:
            hours_next = (hours == 5'd0) ? sclk_pkg::HOUR_MAX : hours - 5'd1;
          default: ;
        endcase
      end
    endcase

    // One second passed: idle count, timeout and time carry chain
    if (sec_done) begin
      if (idle_seconds < sclk_pkg::IDLE_MAX) begin
        idle_seconds_next = idle_seconds + 5'd1;
        if (idle_seconds_next == timeout) mode_next = sclk_pkg::MODE_NORMAL;
      end
      if (seconds >= sclk_pkg::SEC_MAX) begin
        seconds_next = 6'd0;
        if (minutes >= sclk_pkg::MIN_MAX) begin
          minutes_next = 6'd0;
          hours_next   = (hours >= sclk_pkg::HOUR_MAX) ? 5'd0 : hours + 5'd1;
        end else begin
          minutes_next = minutes + 6'd1;
        end
      end else begin
        seconds_next = seconds + 6'd1;
      end
    end

    blank_next = (mode_next != sclk_pkg::MODE_NORMAL) &&
                 (tick_count_next < blank_ticks) && events.keys_idle;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 4'd0;
      seconds      <= 6'd0;
      minutes      <= 6'd0;
      hours        <= 5'd0;
      mode         <= sclk_pkg::MODE_NORMAL;
      idle_seconds <= 5'd0;
    end else if (in_fire) begin
      tick_count   <= tick_count_next;
      seconds      <= seconds_next;
      minutes      <= minutes_next;
      hours        <= hours_next;
      mode         <= mode_next;
      idle_seconds <= idle_seconds_next;
    end
  end

  // Display word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      display.valid <= 1'b0;
    end else if (in_fire) begin
      display.valid <= 1'b1;
    end else if (display.ready) begin
      display.valid <= 1'b0;
    end
  end

  // Display word payload, split into BCD digits
  always_ff @(posedge clk) begin
    if (in_fire) begin
      display.sec_ones       <= sclk_pkg::ones_of(seconds_next);
      display.sec_tens       <= sclk_pkg::tens_of(seconds_next);
      display.min_ones       <= sclk_pkg::ones_of(minutes_next);
      display.min_tens       <= sclk_pkg::tens_of(minutes_next);
      display.hour_ones      <= sclk_pkg::ones_of({1'b0, hours_next});
      display.hour_tens      <= 2'(sclk_pkg::tens_of({1'b0, hours_next}));
      display.set_mode       <= mode_next;
      display.blank_selected <= blank_next;
    end
  end

  // Checks
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    seconds <= sclk_pkg::SEC_MAX && minutes <= sclk_pkg::MIN_MAX &&
    hours <= sclk_pkg::HOUR_MAX)
    else $error("clock state out of range");

  a_word_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> display.valid)
    else $error("accepted event gave no display word");

  a_mode_key_clears_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && events.func == sclk_pkg::FUNC_MODE |=> idle_seconds == 5'd0)
    else $error("mode key did not clear idle count");

  a_no_blank_normal: assert property (@(posedge clk) disable iff (rst)
    display.valid && display.set_mode == sclk_pkg::MODE_NORMAL |-> !display.blank_selected)
    else $error("blank flag set in normal mode");

  a_display_matches_state: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> display.set_mode == mode)
    else $error("display mode differs from state");

endmodule

// ----- test/tb_settable_clock_with_timeout.sv -----
// Testbench for the settable clock: directed table, random event bursts, word checker.
module tb_settable_clock_with_timeout;

  // One display word as the block presents it
  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hour_ones;
    logic [1:0] hour_tens;
    logic [1:0] set_mode;
    logic       blank_selected;
  } disp_t;

  // Directed stimulus row; lit marks a hand-typed expectation
  typedef struct packed {
    logic [1:0] func;
    logic       keys_idle;
    logic       lit;
    disp_t      want;
  } row_t;

  localparam int NUM_PHASES = 6;
  localparam int PHASE_WORDS = 238;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sclk_in_if  events_ch ();
  sclk_out_if display_ch ();
  sclk_cfg_if cfg_ch ();

  settable_clock_with_timeout dut (
    .clk     (clk),
    .rst     (rst),
    .events  (events_ch),
    .display (display_ch),
    .cfg     (cfg_ch)
  );

  always #4 clk = ~clk;

  // Settings walked by the random phases: low extremes, high extremes, zeros, others
  int phase_tps [NUM_PHASES]     = '{1, 15, 0, 3, 2, 10};
  int phase_blank [NUM_PHASES]   = '{0, 15, 7, 2, 1, 5};
  int phase_timeout [NUM_PHASES] = '{1, 31, 0, 5, 3, 20};

  // Shadow of the clock: registers and state
  logic [3:0] tps_reg;
  logic [3:0] blank_reg;
  logic [4:0] timeout_reg;
  logic [3:0] tick_cnt;
  logic [5:0] secs;
  logic [5:0] mins;
  logic [4:0] hrs;
  logic [1:0] cur_mode;
  logic [4:0] idle_secs;

  disp_t display_due [$];
  int    mismatches = 0;
  int    snd_idle_pct = 34;
  int    rcv_idle_pct = 57;

  function automatic disp_t show(int s, int m, int h, logic [1:0] md, logic b);
    disp_t d;
    d.sec_ones       = 4'(s % 10);
    d.sec_tens       = 3'(s / 10);
    d.min_ones       = 4'(m % 10);
    d.min_tens       = 3'(m / 10);
    d.hour_ones      = 4'(h % 10);
    d.hour_tens      = 2'(h / 10);
    d.set_mode       = md;
    d.blank_selected = b;
    return d;
  endfunction

  function automatic row_t row_lit(logic [1:0] f, logic k, disp_t want);
    return '{f, k, 1'b1, want};
  endfunction

  function automatic row_t row_pred(logic [1:0] f, logic k);
    return '{f, k, 1'b0, '0};
  endfunction

  function automatic void reset_clock_shadow();
    tps_reg     = sclk_pkg::TPS_RESET;
    blank_reg   = sclk_pkg::BLANK_RESET;
    timeout_reg = sclk_pkg::TIMEOUT_RESET;
    tick_cnt    = '0;
    secs        = '0;
    mins        = '0;
    hrs         = '0;
    cur_mode    = sclk_pkg::MODE_NORMAL;
    idle_secs   = '0;
  endfunction

  // One whole second: idle count (saturating, may end set mode), then time with carries
  function automatic void second_elapsed();
    if (idle_secs < sclk_pkg::IDLE_MAX) begin
      idle_secs = idle_secs + 5'd1;
      if (idle_secs == timeout_reg) cur_mode = sclk_pkg::MODE_NORMAL;
    end
    if (secs >= sclk_pkg::SEC_MAX) begin
      secs = '0;
      if (mins >= sclk_pkg::MIN_MAX) begin
        mins = '0;
        hrs  = (hrs >= sclk_pkg::HOUR_MAX) ? 5'd0 : hrs + 5'd1;
      end else begin
        mins = mins + 6'd1;
      end
    end else begin
      secs = secs + 6'd1;
    end
  endfunction

  // Apply one event word to the shadow and return the word the block should show
  function automatic disp_t clock_advance(logic [1:0] f, logic idle);
    case (f)
      sclk_pkg::FUNC_TICK: begin
        tick_cnt = tick_cnt + 4'd1;
        // a zero setting behaves as one: the wrapped count also ends the second
        if (tick_cnt >= tps_reg || tick_cnt == 4'd0) begin
          tick_cnt = '0;
          second_elapsed();
        end
      end
      sclk_pkg::FUNC_MODE: begin
        cur_mode  = cur_mode + 2'd1;
        idle_secs = '0;
      end
      sclk_pkg::FUNC_UP: begin
        case (cur_mode)
          sclk_pkg::MODE_SEC:  secs = (secs >= sclk_pkg::SEC_MAX) ? 6'd0 : secs + 6'd1;
          sclk_pkg::MODE_MIN:  mins = (mins >= sclk_pkg::MIN_MAX) ? 6'd0 : mins + 6'd1;
          sclk_pkg::MODE_HOUR: hrs  = (hrs >= sclk_pkg::HOUR_MAX) ? 5'd0 : hrs + 5'd1;
          default: ;
        endcase
      end
      default: begin
        case (cur_mode)
          sclk_pkg::MODE_SEC:  secs = (secs == 6'd0) ? sclk_pkg::SEC_MAX : secs - 6'd1;
          sclk_pkg::MODE_MIN:  mins = (mins == 6'd0) ? sclk_pkg::MIN_MAX : mins - 6'd1;
          sclk_pkg::MODE_HOUR: hrs  = (hrs == 5'd0) ? sclk_pkg::HOUR_MAX : hrs - 5'd1;
          default: ;
        endcase
      end
    endcase
    return show(secs, mins, hrs, cur_mode,
                cur_mode != sclk_pkg::MODE_NORMAL && tick_cnt < blank_reg && idle);
  endfunction

  // Present one event word after a random gap; valid stays high on exit
  task automatic send_event(logic [1:0] f, logic k, logic use_lit, disp_t lit);
    disp_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      events_ch.valid <= 1'b0;
      @(posedge clk);
    end
    events_ch.valid     <= 1'b1;
    events_ch.func      <= f;
    events_ch.keys_idle <= k;
    do @(posedge clk); while (!events_ch.ready);
    pred = clock_advance(f, k);
    display_due.push_back(use_lit ? lit : pred);
  endtask

  // Drop valid and hold off until every expected display word has come back
  task automatic await_drained();
    events_ch.valid <= 1'b0;
    @(posedge clk);
    while (display_due.size() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back; only while the block is idle
  task automatic set_clock_config(int t, int b, int o);
    logic [1:0] idx [3];
    int         val [3];
    idx = '{sclk_pkg::REG_TPS, sclk_pkg::REG_BLANK, sclk_pkg::REG_TIMEOUT};
    val = '{t, b, o};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= 5'(val[i]);
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        sclk_pkg::REG_TPS:   tps_reg = 4'(val[i]);
        sclk_pkg::REG_BLANK: blank_reg = 4'(val[i]);
        default:             timeout_reg = 5'(val[i]);
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random back-pressure on the display channel
  always @(posedge clk) begin
    display_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Checker: each accepted display word against the oldest expectation
  always @(posedge clk) begin
    disp_t got;
    disp_t want;
    if (!rst && display_ch.valid && display_ch.ready) begin
      got = {display_ch.sec_ones, display_ch.sec_tens, display_ch.min_ones,
             display_ch.min_tens, display_ch.hour_ones, display_ch.hour_tens,
             display_ch.set_mode, display_ch.blank_selected};
      if (display_due.size() == 0) begin
        $error("display word with nothing expected");
        mismatches++;
      end else begin
        want = display_due.pop_front();
        check_field("sec_ones", want.sec_ones, got.sec_ones);
        check_field("sec_tens", want.sec_tens, got.sec_tens);
        check_field("min_ones", want.min_ones, got.min_ones);
        check_field("min_tens", want.min_tens, got.min_tens);
        check_field("hour_ones", want.hour_ones, got.hour_ones);
        check_field("hour_tens", want.hour_tens, got.hour_tens);
        check_field("set_mode", want.set_mode, got.set_mode);
        check_field("blank_selected", want.blank_selected, got.blank_selected);
      end
    end
  end

  // Stimulus
  initial begin
    row_t       dir_rows [23];
    int         sent;
    int         burst_len;
    int         burst_kind;
    bit         paused;
    logic [1:0] f;

    events_ch.valid     <= 1'b0;
    events_ch.func      <= sclk_pkg::FUNC_TICK;
    events_ch.keys_idle <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= sclk_pkg::REG_TPS;
    cfg_ch.data         <= '0;
    reset_clock_shadow();

    // Walk every set mode, both wraps of seconds and hours, the down wrap of minutes, then a midnight rollover
    dir_rows = '{
      row_lit(sclk_pkg::FUNC_TICK, 1'b1, show(0, 0, 0, sclk_pkg::MODE_NORMAL, 1'b0)),
      row_lit(sclk_pkg::FUNC_UP, 1'b0, show(0, 0, 0, sclk_pkg::MODE_NORMAL, 1'b0)),
      row_lit(sclk_pkg::FUNC_DOWN, 1'b1, show(0, 0, 0, sclk_pkg::MODE_NORMAL, 1'b0)),
      row_lit(sclk_pkg::FUNC_MODE, 1'b1, show(0, 0, 0, sclk_pkg::MODE_SEC, 1'b1)),
      row_lit(sclk_pkg::FUNC_DOWN, 1'b1, show(59, 0, 0, sclk_pkg::MODE_SEC, 1'b1)),
      row_lit(sclk_pkg::FUNC_UP, 1'b0, show(0, 0, 0, sclk_pkg::MODE_SEC, 1'b0)),
      row_lit(sclk_pkg::FUNC_DOWN, 1'b0, show(59, 0, 0, sclk_pkg::MODE_SEC, 1'b0)),
      row_pred(sclk_pkg::FUNC_MODE, 1'b1),
      row_pred(sclk_pkg::FUNC_DOWN, 1'b1),
      row_pred(sclk_pkg::FUNC_MODE, 1'b1),
      row_lit(sclk_pkg::FUNC_DOWN, 1'b1, show(59, 59, 23, sclk_pkg::MODE_HOUR, 1'b1)),
      row_pred(sclk_pkg::FUNC_UP, 1'b1),
      row_pred(sclk_pkg::FUNC_DOWN, 1'b1),
      row_pred(sclk_pkg::FUNC_MODE, 1'b0),
      row_pred(sclk_pkg::FUNC_TICK, 1'b1),
      row_pred(sclk_pkg::FUNC_TICK, 1'b0),
      row_pred(sclk_pkg::FUNC_TICK, 1'b1),
      row_pred(sclk_pkg::FUNC_TICK, 1'b0),
      row_pred(sclk_pkg::FUNC_TICK, 1'b1),
      row_pred(sclk_pkg::FUNC_TICK, 1'b0),
      row_pred(sclk_pkg::FUNC_TICK, 1'b1),
      row_pred(sclk_pkg::FUNC_TICK, 1'b0),
      row_lit(sclk_pkg::FUNC_TICK, 1'b1, show(0, 0, 0, sclk_pkg::MODE_NORMAL, 1'b0))
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_event(dir_rows[i].func, dir_rows[i].keys_idle, dir_rows[i].lit, dir_rows[i].want);

    // Random phases, each under its own register setting, in pairs that share an idling mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      await_drained();
      repeat (2) @(posedge clk);
      set_clock_config(phase_tps[ph], phase_blank[ph], phase_timeout[ph]);
      snd_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 57 : 0;
      rcv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 34 : 0;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_WORDS) begin
        // bursts: long tick runs let seconds pass and timeouts fire, key runs set the time
        burst_kind = $urandom_range(2);
        burst_len  = $urandom_range(60, 4);
        for (int k = 0; k < burst_len && sent < PHASE_WORDS; k++) begin
          case (burst_kind)
            0:       f = ($urandom_range(24) == 0) ? sclk_pkg::FUNC_MODE : sclk_pkg::FUNC_TICK;
            1:       f = 2'($urandom_range(3));
            default: f = ($urandom_range(1) == 0) ? sclk_pkg::FUNC_TICK : 2'($urandom_range(3));
          endcase
          send_event(f, 1'($urandom_range(1)), 1'b0, '0);
          sent++;
          if (ph == 1 && !paused && sent >= PHASE_WORDS / 2) begin
            await_drained();
            paused = 1'b1;
          end
        end
      end
    end

    await_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && display_due.size() == 0) begin
      $display("settable_clock_with_timeout test passed");
    end else begin
      $display("settable_clock_with_timeout test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #1600000;
    $display("settable_clock_with_timeout test failed");
    $finish;
  end

endmodule
